>>> sv/lje_pkg.sv
`timescale 1ns / 1ps
// Package for the Lennard-Jones energy accumulator: request and result types,
// command and status structs, the micro-op program and shared arithmetic helpers.
// No dependencies.
package lje_pkg;

    localparam int ENERGY_FRAC_BITS = 32;
    localparam int LJ_SHIFT = 46 - ENERGY_FRAC_BITS;
    localparam int TAIL_SHIFT = 60 - ENERGY_FRAC_BITS;
    localparam logic [63:0] TAIL_K_Q28 = 64'd4497679235;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] POS_CAP = {1'b0, {63{1'b1}}};
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] LJ_PC = 5'd0;
    localparam logic [PC_W-1:0] TAIL_PC = 5'd8;

    localparam logic [1:0] ACT_PAIR = 2'd0;
    localparam logic [1:0] ACT_SELF = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] REG_TAIL_ON = 2'd0;
    localparam logic [1:0] REG_CUTOFF = 2'd1;
    localparam logic [1:0] REG_VOLUME = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] eps_a;
        logic [31:0] eps_b;
        logic [31:0] sig_a;
        logic [31:0] sig_b;
        logic [31:0] distance;
        logic        frozen;
    } item_t;

    typedef struct packed {
        logic signed [63:0] total_energy;
        logic signed [63:0] lj_energy;
        logic signed [63:0] pair_tail_energy;
        logic signed [63:0] self_tail_energy;
        logic               saturated;
    } result_t;

    typedef enum logic [1:0] {UK_MUL, UK_DIV, UK_DIFF, UK_ACC} kind_t;
    typedef enum logic [2:0] {SRC_EPS, SRC_SIG, SRC_X, SRC_Y, SRC_Z, SRC_W, SRC_K} src_t;
    typedef enum logic [1:0] {DST_X, DST_Y, DST_Z, DST_W} dst_t;
    typedef enum logic [2:0] {SH_Q32, SH_LJ, SH_EPS, SH_TAIL, SH_FULL} shift_t;
    typedef enum logic [1:0] {DV_DIST, DV_CUT, DV_TAIL} divsel_t;
    typedef enum logic {AC_LJ, AC_TAIL} acc_t;

    typedef struct packed {
        kind_t   kind;
        src_t    src1;
        src_t    src2;
        dst_t    dst;
        shift_t  shift;
        divsel_t divsel;
        acc_t    acc;
        logic    last;
    } uop_t;

    typedef struct packed {
        logic capture;
        logic start_sqrt;
        logic op_start;
        uop_t op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic op_done;
        logic eps_zero;
        logic sig_zero;
        logic lj_en;
        logic tail_on;
        logic res_blocked;
    } stat_t;

    function automatic uop_t mk(kind_t k, src_t a, src_t b, dst_t d, shift_t s,
                                divsel_t v, acc_t c, logic l);
        uop_t u;
        u.kind = k;
        u.src1 = a;
        u.src2 = b;
        u.dst = d;
        u.shift = s;
        u.divsel = v;
        u.acc = c;
        u.last = l;
        return u;
    endfunction

    function automatic uop_t uop_at(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk(UK_DIV, SRC_X, SRC_X, DST_X, SH_Q32, DV_DIST, AC_LJ, 1'b0);
            5'd1:  u = mk(UK_MUL, SRC_X, SRC_X, DST_Y, SH_Q32, DV_DIST, AC_LJ, 1'b0);
            5'd2:  u = mk(UK_MUL, SRC_Y, SRC_Y, DST_Z, SH_Q32, DV_DIST, AC_LJ, 1'b0);
            5'd3:  u = mk(UK_MUL, SRC_Z, SRC_Y, DST_Z, SH_Q32, DV_DIST, AC_LJ, 1'b0);
            5'd4:  u = mk(UK_MUL, SRC_Z, SRC_Z, DST_W, SH_Q32, DV_DIST, AC_LJ, 1'b0);
            5'd5:  u = mk(UK_DIFF, SRC_Z, SRC_W, DST_X, SH_Q32, DV_DIST, AC_LJ, 1'b0);
            5'd6:  u = mk(UK_MUL, SRC_EPS, SRC_X, DST_X, SH_LJ, DV_DIST, AC_LJ, 1'b0);
            5'd7:  u = mk(UK_ACC, SRC_X, SRC_X, DST_X, SH_Q32, DV_DIST, AC_LJ, 1'b1);
            5'd8:  u = mk(UK_DIV, SRC_X, SRC_X, DST_X, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd9:  u = mk(UK_MUL, SRC_X, SRC_X, DST_Y, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd10: u = mk(UK_MUL, SRC_Y, SRC_X, DST_Y, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd11: u = mk(UK_MUL, SRC_Y, SRC_Y, DST_Z, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd12: u = mk(UK_MUL, SRC_Z, SRC_Y, DST_Z, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd13: u = mk(UK_DIFF, SRC_Y, SRC_Z, DST_X, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd14: u = mk(UK_MUL, SRC_SIG, SRC_SIG, DST_Y, SH_FULL, DV_CUT, AC_TAIL, 1'b0);
            5'd15: u = mk(UK_MUL, SRC_Y, SRC_SIG, DST_Y, SH_Q32, DV_CUT, AC_TAIL, 1'b0);
            5'd16: u = mk(UK_MUL, SRC_EPS, SRC_Y, DST_Y, SH_EPS, DV_CUT, AC_TAIL, 1'b0);
            5'd17: u = mk(UK_MUL, SRC_Y, SRC_X, DST_W, SH_FULL, DV_CUT, AC_TAIL, 1'b0);
            5'd18: u = mk(UK_DIV, SRC_X, SRC_X, DST_X, SH_Q32, DV_TAIL, AC_TAIL, 1'b0);
            5'd19: u = mk(UK_MUL, SRC_X, SRC_K, DST_X, SH_TAIL, DV_TAIL, AC_TAIL, 1'b0);
            default: u = mk(UK_ACC, SRC_X, SRC_X, DST_X, SH_Q32, DV_TAIL, AC_TAIL, 1'b1);
        endcase
        return u;
    endfunction

    // Signed saturating add; the top bit of the result is the overflow flag.
    function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [63:0] s;
        logic ovf;
        s = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (ovf)
        begin
            s = b[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        end
        return {ovf, s};
    endfunction

endpackage

>>> sv/lje_ctrl.sv
`timescale 1ns / 1ps
// Controller of the Lennard-Jones energy accumulator: request decode and the
// micro-op sequencer. Depends on lje_pkg.
module lje_ctrl
    import lje_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SQRT  = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic accept;
    uop_t op;

    assign op = uop_at(pc_reg);
    assign item_stall = (state_reg != ST_IDLE) || stat.res_blocked;
    assign accept = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        cmd.capture = accept;
        cmd.start_sqrt = 1'b0;
        cmd.op_start = 1'b0;
        cmd.op = op;
        cmd.emit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_PAIR:
                        begin
                            cmd.start_sqrt = 1'b1;
                            state_next = ST_SQRT;
                        end
                        ACT_SELF:
                        begin
                            if (stat.tail_on && !item.frozen && item.eps_a != 32'd0
                                && item.sig_a != 32'd0)
                            begin
                                pc_next = TAIL_PC;
                                state_next = ST_ISSUE;
                            end
                        end
                        ACT_FINISH: cmd.emit = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    if (stat.eps_zero || stat.sig_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pc_next = stat.lj_en ? LJ_PC : TAIL_PC;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.op_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.op_done)
                begin
                    if (!op.last)
                    begin
                        pc_next = pc_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                    else if (op.acc == AC_LJ && stat.tail_on)
                    begin
                        pc_next = TAIL_PC;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= LJ_PC;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
        end
    end

endmodule

>>> sv/lje_datapath.sv
`timescale 1ns / 1ps
// Datapath of the Lennard-Jones energy accumulator: configuration, square root,
// shared multiplier and divider, working registers, sums and result register.
// Depends on lje_pkg.
module lje_datapath
    import lje_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  item_t       item,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    logic        tail_on_reg;
    logic [31:0] cutoff_reg;
    logic [47:0] volume_reg;

    logic [31:0] eps_reg, sig_reg, dist_reg;
    logic        self_reg;
    logic [63:0] x_reg, y_reg, z_reg, w_reg, hi_reg;
    logic        neg_reg;

    logic [63:0] sq_x_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg, sq_done_reg;
    logic [63:0] sq_t, sq_x_next, sq_r_next;

    logic         m_busy_reg, m_fin_reg;
    logic [1:0]   m_cnt_reg;
    logic [127:0] m_acc_reg, m_acc_next, m_sh;
    logic [63:0]  m_pp, m_r, m_val;
    logic [31:0]  m_ah, m_bh;
    logic         m_pos, m_ovf;

    logic         d_busy_reg, d_fin_reg, d_over_reg;
    logic [6:0]   d_cnt_reg;
    logic [127:0] d_num_reg;
    logic [47:0]  d_rem_reg, d_den_reg;
    logic [63:0]  d_q_reg;
    logic [48:0]  d_rem_sh;
    logic         d_ge;

    logic         op_done_reg;
    logic [63:0]  a_val, b_val;
    logic signed [63:0] total_reg, lj_reg, pair_reg, self_reg_sum;
    logic         ovf_reg;
    logic signed [63:0] term, target_old;
    logic [64:0]  add_t, add_tot;
    logic [32:0]  sig_sum;

    result_t res_reg;
    logic    res_valid_reg;

    function automatic logic [63:0] pick(src_t s, logic [31:0] e, logic [31:0] g,
                                         logic [63:0] x, logic [63:0] y,
                                         logic [63:0] z, logic [63:0] w);
        logic [63:0] v;
        case (s)
            SRC_EPS: v = {32'd0, e};
            SRC_SIG: v = {32'd0, g};
            SRC_X:   v = x;
            SRC_Y:   v = y;
            SRC_Z:   v = z;
            SRC_W:   v = w;
            SRC_K:   v = TAIL_K_Q28;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    assign a_val = pick(cmd.op.src1, eps_reg, sig_reg, x_reg, y_reg, z_reg, w_reg);
    assign b_val = pick(cmd.op.src2, eps_reg, sig_reg, x_reg, y_reg, z_reg, w_reg);

    // Square root step.
    always_comb
    begin
        sq_t = sq_r_reg + sq_bit_reg;
        if (sq_x_reg >= sq_t)
        begin
            sq_x_next = sq_x_reg - sq_t;
            sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
        end
        else
        begin
            sq_x_next = sq_x_reg;
            sq_r_next = sq_r_reg >> 1;
        end
    end

    // Multiplier: one 32x32 partial product a cycle, then a shift that saturates except for SH_FULL.
    always_comb
    begin
        m_ah = m_cnt_reg[1] ? a_val[63:32] : a_val[31:0];
        m_bh = m_cnt_reg[0] ? b_val[63:32] : b_val[31:0];
        m_pp = m_ah * m_bh;
        case (m_cnt_reg)
            2'd0: m_acc_next = m_acc_reg + {64'd0, m_pp};
            2'd3: m_acc_next = m_acc_reg + {m_pp, 64'd0};
            default: m_acc_next = m_acc_reg + {32'd0, m_pp, 32'd0};
        endcase
        m_pos = 1'b0;
        case (cmd.op.shift)
            SH_Q32: m_sh = m_acc_reg >> 32;
            SH_LJ:
            begin
                m_sh = m_acc_reg >> LJ_SHIFT;
                m_pos = 1'b1;
            end
            SH_EPS: m_sh = m_acc_reg >> 16;
            SH_TAIL:
            begin
                m_sh = m_acc_reg >> TAIL_SHIFT;
                m_pos = 1'b1;
            end
            default: m_sh = m_acc_reg;
        endcase
        m_r = m_sh[63:0];
        m_ovf = (cmd.op.shift != SH_FULL) && ((|m_sh[127:64]) || (m_pos && m_r[63]));
        m_val = m_ovf ? (m_pos ? POS_CAP : ALL_ONES) : m_r;
    end

    // Restoring divider step.
    assign d_rem_sh = {d_rem_reg, d_num_reg[127]};
    assign d_ge = d_rem_sh >= {1'b0, d_den_reg};

    // Accumulation of a finished term.
    assign term = neg_reg ? -$signed(a_val) : $signed(a_val);
    always_comb
    begin
        if (cmd.op.acc == AC_LJ)
        begin
            target_old = lj_reg;
        end
        else if (self_reg)
        begin
            target_old = self_reg_sum;
        end
        else
        begin
            target_old = pair_reg;
        end
    end
    assign add_t = sat_add(target_old, term);
    assign add_tot = sat_add(total_reg, term);
    assign sig_sum = {1'b0, item.sig_a} + {1'b0, item.sig_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_on_reg <= 1'b0;
            cutoff_reg <= 32'd655360;
            volume_reg <= 48'd65536000;
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            m_busy_reg <= 1'b0;
            m_fin_reg <= 1'b0;
            d_busy_reg <= 1'b0;
            d_fin_reg <= 1'b0;
            op_done_reg <= 1'b0;
            total_reg <= '0;
            lj_reg <= '0;
            pair_reg <= '0;
            self_reg_sum <= '0;
            ovf_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            op_done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TAIL_ON: tail_on_reg <= cfg_data[0];
                    REG_CUTOFF:  cutoff_reg <= cfg_data[31:0];
                    REG_VOLUME:  volume_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cmd.capture)
            begin
                dist_reg <= item.distance;
                self_reg <= (item.action == ACT_SELF);
                if (item.action == ACT_SELF)
                begin
                    eps_reg <= item.eps_a;
                    sig_reg <= item.sig_a;
                end
                else
                begin
                    sig_reg <= sig_sum[32:1];
                end
            end
            if (cmd.start_sqrt)
            begin
                sq_x_reg <= item.eps_a * item.eps_b;
                sq_r_reg <= 64'd0;
                sq_bit_reg <= {2'b01, 62'd0};
                sq_cnt_reg <= 5'd31;
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg)
            begin
                sq_x_reg <= sq_x_next;
                sq_r_reg <= sq_r_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == 5'd0)
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                    eps_reg <= sq_r_next[31:0];
                end
            end

            if (cmd.op_start)
            begin
                case (cmd.op.kind)
                    UK_MUL:
                    begin
                        m_busy_reg <= 1'b1;
                        m_cnt_reg <= 2'd0;
                        m_acc_reg <= '0;
                    end
                    UK_DIV:
                    begin
                        d_busy_reg <= 1'b1;
                        d_cnt_reg <= 7'd127;
                        d_rem_reg <= '0;
                        d_over_reg <= 1'b0;
                        case (cmd.op.divsel)
                            DV_DIST:
                            begin
                                d_num_reg <= {64'd0, sig_reg, 32'd0};
                                d_den_reg <= {16'd0, dist_reg};
                            end
                            DV_CUT:
                            begin
                                d_num_reg <= {64'd0, sig_reg, 32'd0};
                                d_den_reg <= {16'd0, cutoff_reg};
                            end
                            default:
                            begin
                                d_num_reg <= {hi_reg, w_reg};
                                d_den_reg <= volume_reg;
                            end
                        endcase
                    end
                    UK_DIFF:
                    begin
                        neg_reg <= a_val > b_val;
                        x_reg <= (a_val > b_val) ? a_val - b_val : b_val - a_val;
                        op_done_reg <= 1'b1;
                    end
                    default:
                    begin
                        total_reg <= $signed(add_tot[63:0]);
                        if (cmd.op.acc == AC_LJ)
                        begin
                            lj_reg <= $signed(add_t[63:0]);
                        end
                        else if (self_reg)
                        begin
                            self_reg_sum <= $signed(add_t[63:0]);
                        end
                        else
                        begin
                            pair_reg <= $signed(add_t[63:0]);
                        end
                        ovf_reg <= ovf_reg | add_t[64] | add_tot[64];
                        op_done_reg <= 1'b1;
                    end
                endcase
            end

            if (m_busy_reg)
            begin
                m_acc_reg <= m_acc_next;
                m_cnt_reg <= m_cnt_reg + 1'b1;
                if (m_cnt_reg == 2'd3)
                begin
                    m_busy_reg <= 1'b0;
                    m_fin_reg <= 1'b1;
                end
            end
            if (m_fin_reg)
            begin
                m_fin_reg <= 1'b0;
                op_done_reg <= 1'b1;
                if (m_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.op.shift == SH_FULL)
                begin
                    hi_reg <= m_acc_reg[127:64];
                end
                case (cmd.op.dst)
                    DST_X: x_reg <= m_val;
                    DST_Y: y_reg <= m_val;
                    DST_Z: z_reg <= m_val;
                    default: w_reg <= m_val;
                endcase
            end

            if (d_busy_reg)
            begin
                d_rem_reg <= d_ge ? 48'(d_rem_sh - {1'b0, d_den_reg}) : d_rem_sh[47:0];
                d_num_reg <= {d_num_reg[126:0], 1'b0};
                d_q_reg <= {d_q_reg[62:0], d_ge};
                if (d_ge && d_cnt_reg[6])
                begin
                    d_over_reg <= 1'b1;
                end
                d_cnt_reg <= d_cnt_reg - 1'b1;
                if (d_cnt_reg == 7'd0)
                begin
                    d_busy_reg <= 1'b0;
                    d_fin_reg <= 1'b1;
                end
            end
            if (d_fin_reg)
            begin
                d_fin_reg <= 1'b0;
                op_done_reg <= 1'b1;
                if (d_over_reg)
                begin
                    ovf_reg <= 1'b1;
                end
                x_reg <= d_over_reg ? ALL_ONES : d_q_reg;
            end

            if (cmd.emit)
            begin
                res_reg.total_energy <= total_reg;
                res_reg.lj_energy <= lj_reg;
                res_reg.pair_tail_energy <= pair_reg;
                res_reg.self_tail_energy <= self_reg_sum;
                res_reg.saturated <= ovf_reg;
                total_reg <= '0;
                lj_reg <= '0;
                pair_reg <= '0;
                self_reg_sum <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    assign stat.sqrt_done = sq_done_reg;
    assign stat.op_done = op_done_reg;
    assign stat.eps_zero = (eps_reg == 32'd0);
    assign stat.sig_zero = (sig_reg == 32'd0);
    assign stat.lj_en = !tail_on_reg || (dist_reg <= cutoff_reg);
    assign stat.tail_on = tail_on_reg;
    assign stat.res_blocked = res_valid_reg && result_stall;

    assign result_valid = res_valid_reg;
    assign result = res_reg;

endmodule

>>> sv/lennard_jones_energy_accumulator.sv
`timescale 1ns / 1ps
// Top level of the Lennard-Jones 12-6 energy accumulator with tail correction.
// Depends on lje_pkg, lje_ctrl and lje_datapath.
//
// A request on the item channel is a pair term, a self-atom tail term or a
// finish. It is taken at a clock edge where item_valid is high and item_stall
// is low. Only a finish produces a result: the four signed Q32.32 totals and
// the sticky saturation flag, which are then cleared.
// The result of a finish is registered and shown in the cycle after it is taken.
// A pair request runs the square root, then the 12-6 term if the distance is
// within the cutoff or the tail is off, then the tail term if the tail is on;
// a self request runs only the tail term, if the tail is on. Each division runs
// on a 128-step bit-serial divider; products use one shared 32x32 multiplier.
// One request is in work at a time; item_stall is high while it runs.
// The result register holds a finished result while result_stall is high;
// meanwhile item_stall is high and no request is taken. Reset clears the
// totals, the flag and the control state and loads the default
// configuration. The user must write configuration with cfg_we only while
// the block is idle; the block itself does not enforce it.
module lennard_jones_energy_accumulator
    import lje_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    cmd_t  cmd;
    stat_t stat;

    lje_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .stat       (stat),
        .cmd        (cmd)
    );

    lje_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
